FILE: rtl/pfe_pkg.sv
// Package for the postfix expression evaluator.
// Holds widths, status and character codes, and the divider request/response structs.
// No dependencies.
package pfe_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DATA_W      = 32;
	localparam int SYM_W       = 8;
	localparam int STAT_W      = 3;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	localparam logic [STAT_W-1:0] STS_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STS_OVERFLOW  = 3'd1;
	localparam logic [STAT_W-1:0] STS_UNDERFLOW = 3'd2;
	localparam logic [STAT_W-1:0] STS_INVALID   = 3'd3;
	localparam logic [STAT_W-1:0] STS_LEFTOVER  = 3'd4;
	localparam logic [STAT_W-1:0] STS_DIVZERO   = 3'd5;

	localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
	localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: rtl/pfe_if.sv
// Handshake interfaces for the expression input and the result output.
// Depends on pfe_pkg for field widths.
interface pfe_expr_if;
	logic                       valid;
	logic                       ready;
	logic [pfe_pkg::SYM_W-1:0]  symbol;
	logic                       last;

	modport source(output valid, output symbol, output last, input ready);
	modport sink(input valid, input symbol, input last, output ready);
endinterface

interface pfe_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [pfe_pkg::DATA_W-1:0] value;
	logic [pfe_pkg::STAT_W-1:0]        status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

FILE: rtl/pfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/pfe_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfe_pkg for widths and the request/response structs.
module pfe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfe_pkg::div_req_t req,
	output pfe_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic                           neg_q;
	logic [pfe_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [pfe_pkg::DATA_W-1:0]     q_q;
	logic [pfe_pkg::DATA_W-1:0]     r_q;
	logic [pfe_pkg::DATA_W-1:0]     d_q;
	logic [pfe_pkg::DATA_W:0]       r_shift;
	logic [pfe_pkg::DATA_W:0]       r_diff;

	assign r_shift = {r_q, q_q[pfe_pkg::DATA_W-1]};
	assign r_diff  = r_shift - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.num[pfe_pkg::DATA_W-1] ^ req.den[pfe_pkg::DATA_W-1];
				q_q    <= req.num[pfe_pkg::DATA_W-1] ? -req.num : req.num;
				d_q    <= req.den[pfe_pkg::DATA_W-1] ? -req.den : req.den;
				r_q    <= '0;
				cnt_q  <= pfe_pkg::DIV_CNT_W'(pfe_pkg::DATA_W - 1);
			end else if (busy_q) begin
				if (!r_diff[pfe_pkg::DATA_W]) begin
					r_q <= r_diff[pfe_pkg::DATA_W-1:0];
					q_q <= {q_q[pfe_pkg::DATA_W-2:0], 1'b1};
				end else begin
					r_q <= r_shift[pfe_pkg::DATA_W-1:0];
					q_q <= {q_q[pfe_pkg::DATA_W-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -q_q : q_q;

endmodule

FILE: rtl/postfix_expression_evaluator_unit.sv
// Top level of the postfix expression evaluator: control, top-of-stack register,
// result register. Depends on pfe_pkg, pfe_if, pfe_ram, pfe_div.
//
// channel  dir  beat payload        note
// expr     in   symbol[7:0], last  one character per beat
// result   out  value[31:0], status one beat per expression, on last
//
// A digit, an error or an ignored character completes in the cycle it is accepted;
// + - * read the second operand from stack memory, then use the ALU; / goes on to
// the divider, one quotient bit per cycle. The top of stack lives in a register,
// the rest in stack RAM. Reset clears registers only; no clearing pass.
// expr stalls while an item is in progress or a result beat is still unaccepted.
module postfix_expression_evaluator_unit (
	input  logic         clk,
	input  logic         arst_n,
	pfe_expr_if.sink     expr,
	pfe_result_if.source result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV
	} state_t;

	state_t                         state_q;
	logic [pfe_pkg::CNT_W-1:0]      cnt_q;
	logic [pfe_pkg::STAT_W-1:0]     err_q;
	logic [pfe_pkg::DATA_W-1:0]     tos_q;
	logic [pfe_pkg::SYM_W-1:0]      op_q;
	logic                           last_q;
	logic                           out_vld_q;
	logic [pfe_pkg::DATA_W-1:0]     out_value_q;
	logic [pfe_pkg::STAT_W-1:0]     out_status_q;

	logic                           acc;
	logic                           is_digit;
	logic                           is_op;
	logic [pfe_pkg::DATA_W-1:0]     digit_val;
	logic                           fin;
	logic                           fin_last;
	logic                           go_exec;
	logic                           out_load;
	logic [pfe_pkg::CNT_W-1:0]      cnt_n;
	logic [pfe_pkg::STAT_W-1:0]     err_n;
	logic [pfe_pkg::DATA_W-1:0]     tos_n;
	logic [pfe_pkg::STAT_W-1:0]     res_status;
	logic [pfe_pkg::DATA_W-1:0]     res_value;
	logic                           mem_we;
	logic                           mem_re;
	logic [pfe_pkg::CNT_W-1:0]      waddr_full;
	logic [pfe_pkg::CNT_W-1:0]      raddr_full;
	logic [pfe_pkg::DATA_W-1:0]     rd_data;
	pfe_pkg::div_req_t              div_req;
	pfe_pkg::div_rsp_t              div_rsp;

	assign expr.ready = (state_q == ST_IDLE) && (!out_vld_q || result.ready);
	assign acc        = expr.valid && expr.ready;
	assign is_digit   = (expr.symbol >= pfe_pkg::CH_ZERO) && (expr.symbol <= pfe_pkg::CH_NINE);
	assign is_op      = (expr.symbol == pfe_pkg::CH_PLUS) || (expr.symbol == pfe_pkg::CH_MINUS)
		|| (expr.symbol == pfe_pkg::CH_MUL) || (expr.symbol == pfe_pkg::CH_DIV);
	assign digit_val  = pfe_pkg::DATA_W'(expr.symbol - pfe_pkg::CH_ZERO);
	assign waddr_full = cnt_q - pfe_pkg::CNT_W'(1);
	assign raddr_full = cnt_q - pfe_pkg::CNT_W'(2);

	pfe_ram #(
		.WIDTH(pfe_pkg::DATA_W),
		.DEPTH(pfe_pkg::STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(waddr_full[pfe_pkg::ADDR_W-1:0]),
		.wdata(tos_q),
		.re   (mem_re),
		.raddr(raddr_full[pfe_pkg::ADDR_W-1:0]),
		.rdata(rd_data)
	);

	pfe_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		fin          = 1'b0;
		fin_last     = 1'b0;
		go_exec      = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		cnt_n        = cnt_q;
		err_n        = err_q;
		tos_n        = tos_q;
		div_req      = '0;
		div_req.num  = rd_data;
		div_req.den  = tos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					fin_last = expr.last;
					if (err_q != pfe_pkg::STS_OK) begin
						fin = 1'b1;
					end else if (is_digit) begin
						fin = 1'b1;
						if (cnt_q == pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH)) begin
							err_n = pfe_pkg::STS_OVERFLOW;
						end else begin
							mem_we = (cnt_q != '0);
							tos_n  = digit_val;
							cnt_n  = cnt_q + 1'b1;
						end
					end else if (cnt_q < pfe_pkg::CNT_W'(2)) begin
						fin   = 1'b1;
						err_n = pfe_pkg::STS_UNDERFLOW;
					end else if (!is_op) begin
						fin   = 1'b1;
						err_n = pfe_pkg::STS_INVALID;
					end else if ((expr.symbol == pfe_pkg::CH_DIV) && (tos_q == '0)) begin
						fin   = 1'b1;
						err_n = pfe_pkg::STS_DIVZERO;
					end else begin
						mem_re  = 1'b1;
						go_exec = 1'b1;
					end
				end
			end
			ST_EXEC: begin
				fin_last = last_q;
				case (op_q)
					pfe_pkg::CH_PLUS: begin
						fin   = 1'b1;
						tos_n = rd_data + tos_q;
						cnt_n = cnt_q - 1'b1;
					end
					pfe_pkg::CH_MINUS: begin
						fin   = 1'b1;
						tos_n = rd_data - tos_q;
						cnt_n = cnt_q - 1'b1;
					end
					pfe_pkg::CH_DIV: begin
						div_req.start = 1'b1;
					end
					default: begin
						fin   = 1'b1;
						tos_n = rd_data * tos_q;
						cnt_n = cnt_q - 1'b1;
					end
				endcase
			end
			ST_DIV: begin
				fin_last = last_q;
				if (div_rsp.done) begin
					fin   = 1'b1;
					tos_n = div_rsp.quot;
					cnt_n = cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_value = '0;
		if (err_n != pfe_pkg::STS_OK) begin
			res_status = err_n;
		end else if (cnt_n != pfe_pkg::CNT_W'(1)) begin
			res_status = pfe_pkg::STS_LEFTOVER;
		end else begin
			res_status = pfe_pkg::STS_OK;
			res_value  = tos_n;
		end
	end

	assign out_load = fin && fin_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			err_q        <= pfe_pkg::STS_OK;
			tos_q        <= '0;
			op_q         <= '0;
			last_q       <= 1'b0;
			out_vld_q    <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= pfe_pkg::STS_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go_exec) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= (op_q == pfe_pkg::CH_DIV) ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (go_exec) begin
				op_q   <= expr.symbol;
				last_q <= expr.last;
			end
			tos_q <= tos_n;
			if (out_load) begin
				cnt_q <= '0;
				err_q <= pfe_pkg::STS_OK;
			end else begin
				cnt_q <= cnt_n;
				err_q <= err_n;
			end
			if (out_load) begin
				out_vld_q    <= 1'b1;
				out_value_q  <= res_value;
				out_status_q <= res_status;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign result.valid  = out_vld_q;
	assign result.value  = out_value_q;
	assign result.status = out_status_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result.ready) |-> !out_load)
		else $error("pending result overwritten");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done outside divide state");

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_status_q != pfe_pkg::STS_OK)) |-> (out_value_q == '0))
		else $error("nonzero value with error status");

	a_exec_has_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> (cnt_q >= pfe_pkg::CNT_W'(2)))
		else $error("operator executing with fewer than two values");
`endif

endmodule
